### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CFQR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Condition that forces a consequence in the following cycle.
`define CFQR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cfqr_pkg.sv
// Types and constants shared by the CAN frame queue router.
`default_nettype none

package cfqr_pkg;

  // Field widths of one frame.
  localparam int ID_W   = 29;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int FUNC_W = 3;
  localparam int TXS_W  = 2;
  localparam int WORD_W = ID_W + LEN_W + DATA_W;

  // Number of ring queues.
  localparam int NUM_Q = 5;

  // Longest data length; larger codes saturate to it.
  localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

  // The diagnostic window spans 2**DIAG_WIN_BITS identifiers.
  localparam int DIAG_WIN_BITS = 8;

  // Configuration register reset values.
  localparam logic [ID_W-1:0] APP_RX_ID_RST    = 29'h0;
  localparam logic [ID_W-1:0] DIAG_ID_BASE_RST = 29'h700;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_APP_RX_ID    = 1'b0,
    REG_DIAG_ID_BASE = 1'b1
  } cfg_reg_t;

  // Operation codes of an input word.
  typedef enum logic [FUNC_W-1:0] {
    FN_RX_FRAME     = 3'd0,
    FN_APP_SEND     = 3'd1,
    FN_DIAG_SEND    = 3'd2,
    FN_TX_READ      = 3'd3,
    FN_APP_RX_READ  = 3'd4,
    FN_DIAG_RX_READ = 3'd5,
    FN_MON_READ     = 3'd6
  } func_t;

  // Queue numbers; the four primary queues share one memory.
  typedef enum logic [2:0] {
    Q_DIAG_RX = 3'd0,
    Q_APP_RX  = 3'd1,
    Q_DIAG_TX = 3'd2,
    Q_APP_TX  = 3'd3,
    Q_MON     = 3'd4
  } queue_t;

  // Origin of a frame returned by a tx read.
  typedef enum logic [TXS_W-1:0] {
    TX_SRC_NONE = 2'd0,
    TX_SRC_DIAG = 2'd1,
    TX_SRC_APP  = 2'd2
  } tx_src_t;

  // Result flags of one word, plus which memory holds the popped frame.
  typedef struct packed {
    logic    found;
    tx_src_t tx_source;
    logic    stored_primary;
    logic    stored_monitor;
    logic    from_mon;
  } stage_flags_t;

endpackage

`default_nettype wire

### hw/rtl/cfqr_intf.sv
// Valid/ready channel interfaces for input words and result words.
`default_nettype none

interface cfqr_in_if;
  logic                          valid;
  logic                          ready;
  logic [cfqr_pkg::FUNC_W-1:0]   func;
  logic [cfqr_pkg::ID_W-1:0]     frame_id;
  logic [cfqr_pkg::LEN_W-1:0]    frame_len;
  logic [cfqr_pkg::DATA_W-1:0]   frame_data;

  modport source (output valid, func, frame_id, frame_len, frame_data, input ready);
  modport sink   (input valid, func, frame_id, frame_len, frame_data, output ready);
endinterface

interface cfqr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [cfqr_pkg::ID_W-1:0]     out_id;
  logic [cfqr_pkg::LEN_W-1:0]    out_len;
  logic [cfqr_pkg::DATA_W-1:0]   out_data;
  logic [cfqr_pkg::TXS_W-1:0]    tx_source;
  logic                          stored_primary;
  logic                          stored_monitor;

  modport source (output valid, found, out_id, out_len, out_data, tx_source,
                  stored_primary, stored_monitor, input ready);
  modport sink   (input valid, found, out_id, out_len, out_data, tx_source,
                  stored_primary, stored_monitor, output ready);
endinterface

`default_nettype wire

### hw/rtl/cfqr_frame_mem.sv
// Frame store: one write port and one read port with registered read data.
`default_nettype none

module cfqr_frame_mem #(
  parameter int AW = 4,
  parameter int DW = 97
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [2**AW];
  logic [DW-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/cfqr_queue_ctrl.sv
// Queue pointers, full flags, routing decision and memory addressing.
`default_nettype none

module cfqr_queue_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  localparam int PW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          fire,
  input  wire cfqr_pkg::func_t               func,
  input  wire logic [cfqr_pkg::ID_W-1:0]     frame_id,
  input  wire logic [cfqr_pkg::ID_W-1:0]     app_rx_id,
  input  wire logic [cfqr_pkg::ID_W-1:0]     diag_id_base,
  output logic                               pri_we,
  output logic      [PW+1:0]                 pri_waddr,
  output logic                               mon_we,
  output logic      [PW-1:0]                 mon_waddr,
  output logic                               pri_re,
  output logic      [PW+1:0]                 pri_raddr,
  output logic                               mon_re,
  output logic      [PW-1:0]                 mon_raddr,
  output cfqr_pkg::stage_flags_t             flags
);

  localparam int NQ = cfqr_pkg::NUM_Q;
  localparam int IW = cfqr_pkg::ID_W;

  logic [PW-1:0] rd_ptr_r   [NQ];
  logic [PW-1:0] wr_ptr_r   [NQ];
  logic [PW-1:0] rd_ptr_nxt [NQ];
  logic [PW-1:0] wr_ptr_nxt [NQ];
  logic [NQ-1:0] full_r;
  logic [NQ-1:0] full_nxt;
  logic [NQ-1:0] nonempty;
  logic [NQ-1:0] can_push;
  logic [NQ-1:0] push_q;
  logic [NQ-1:0] pop_q;
  logic [IW:0]   win_diff;
  logic          in_window;
  cfqr_pkg::queue_t pri_q;
  cfqr_pkg::queue_t rd_q;

  // Ring pointer advance with wrap at the queue depth.
  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  // Per-queue occupancy.
  always_comb begin
    for (int q = 0; q < NQ; q++) begin
      nonempty[q] = (rd_ptr_r[q] != wr_ptr_r[q]) || full_r[q];
      can_push[q] = !full_r[q];
    end
  end

  // Diagnostic window test without wrap past the top identifier.
  assign win_diff  = {1'b0, frame_id} - {1'b0, diag_id_base};
  assign in_window = !win_diff[IW] && (win_diff[IW-1:cfqr_pkg::DIAG_WIN_BITS] == '0);

  // Routing decision for the word in flight.
  always_comb begin
    push_q = '0;
    pop_q  = '0;
    flags  = '0;
    pri_q  = cfqr_pkg::Q_DIAG_RX;
    rd_q   = cfqr_pkg::Q_DIAG_RX;
    if (fire) begin
      unique case (func)
        cfqr_pkg::FN_RX_FRAME: begin
          if (in_window) begin
            pri_q                  = cfqr_pkg::Q_DIAG_RX;
            push_q[cfqr_pkg::Q_DIAG_RX] = can_push[cfqr_pkg::Q_DIAG_RX];
            push_q[cfqr_pkg::Q_MON]     = can_push[cfqr_pkg::Q_MON];
          end else if (frame_id == app_rx_id) begin
            pri_q                  = cfqr_pkg::Q_APP_RX;
            push_q[cfqr_pkg::Q_APP_RX]  = can_push[cfqr_pkg::Q_APP_RX];
          end
        end
        cfqr_pkg::FN_APP_SEND: begin
          pri_q                    = cfqr_pkg::Q_APP_TX;
          push_q[cfqr_pkg::Q_APP_TX] = can_push[cfqr_pkg::Q_APP_TX];
          push_q[cfqr_pkg::Q_MON]    = can_push[cfqr_pkg::Q_MON];
        end
        cfqr_pkg::FN_DIAG_SEND: begin
          pri_q                     = cfqr_pkg::Q_DIAG_TX;
          push_q[cfqr_pkg::Q_DIAG_TX] = can_push[cfqr_pkg::Q_DIAG_TX];
          push_q[cfqr_pkg::Q_MON]     = can_push[cfqr_pkg::Q_MON];
        end
        cfqr_pkg::FN_TX_READ: begin
          // Diagnostic tx has priority over application tx.
          if (nonempty[cfqr_pkg::Q_DIAG_TX]) begin
            rd_q            = cfqr_pkg::Q_DIAG_TX;
            flags.tx_source = cfqr_pkg::TX_SRC_DIAG;
          end else begin
            rd_q            = cfqr_pkg::Q_APP_TX;
            flags.tx_source = nonempty[cfqr_pkg::Q_APP_TX] ? cfqr_pkg::TX_SRC_APP
                                                           : cfqr_pkg::TX_SRC_NONE;
          end
          pop_q[rd_q] = nonempty[rd_q];
        end
        cfqr_pkg::FN_APP_RX_READ: begin
          rd_q        = cfqr_pkg::Q_APP_RX;
          pop_q[rd_q] = nonempty[rd_q];
        end
        cfqr_pkg::FN_DIAG_RX_READ: begin
          rd_q        = cfqr_pkg::Q_DIAG_RX;
          pop_q[rd_q] = nonempty[rd_q];
        end
        cfqr_pkg::FN_MON_READ: begin
          rd_q        = cfqr_pkg::Q_MON;
          pop_q[rd_q] = nonempty[rd_q];
        end
        default: begin
        end
      endcase
    end
    flags.found          = |pop_q;
    flags.from_mon       = pop_q[cfqr_pkg::Q_MON];
    flags.stored_primary = |push_q[cfqr_pkg::Q_APP_TX:cfqr_pkg::Q_DIAG_RX];
    flags.stored_monitor = push_q[cfqr_pkg::Q_MON];
  end

  // Memory requests: primary queues are addressed by queue number and pointer.
  assign pri_we    = |push_q[cfqr_pkg::Q_APP_TX:cfqr_pkg::Q_DIAG_RX];
  assign pri_waddr = {pri_q[1:0], wr_ptr_r[pri_q]};
  assign mon_we    = push_q[cfqr_pkg::Q_MON];
  assign mon_waddr = wr_ptr_r[cfqr_pkg::Q_MON];
  assign pri_re    = |pop_q[cfqr_pkg::Q_APP_TX:cfqr_pkg::Q_DIAG_RX];
  assign pri_raddr = {rd_q[1:0], rd_ptr_r[rd_q]};
  assign mon_re    = pop_q[cfqr_pkg::Q_MON];
  assign mon_raddr = rd_ptr_r[cfqr_pkg::Q_MON];

  // Next pointer and full flag values; a queue is never pushed and popped together.
  always_comb begin
    for (int q = 0; q < NQ; q++) begin
      rd_ptr_nxt[q] = rd_ptr_r[q];
      wr_ptr_nxt[q] = wr_ptr_r[q];
      full_nxt[q]   = full_r[q];
      if (push_q[q]) begin
        wr_ptr_nxt[q] = next_ptr(wr_ptr_r[q]);
        full_nxt[q]   = (next_ptr(wr_ptr_r[q]) == rd_ptr_r[q]);
      end
      if (pop_q[q]) begin
        rd_ptr_nxt[q] = next_ptr(rd_ptr_r[q]);
        full_nxt[q]   = 1'b0;
      end
    end
  end

  // Pointer and flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NQ; q++) begin
        rd_ptr_r[q] <= '0;
        wr_ptr_r[q] <= '0;
      end
      full_r <= '0;
    end else begin
      for (int q = 0; q < NQ; q++) begin
        rd_ptr_r[q] <= rd_ptr_nxt[q];
        wr_ptr_r[q] <= wr_ptr_nxt[q];
      end
      full_r <= full_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/can_frame_queue_router_core.sv
// Top level of the CAN frame queue router: five frame queues behind one word channel.
//
//   Channel | Direction | Handshake    | Contents
//   --------+-----------+--------------+-------------------------------------------
//   in_if   | in        | valid/ready  | func, frame_id, frame_len, frame_data
//   out_if  | out       | valid/ready  | found, out_id, out_len, out_data, flags
//   cfg_*   | in        | write enable | register index, 29-bit write data
//
// The accepting edge loads the input register; once the result register is free or being
// taken, the word fires: the pointers update, the synchronous memory access is done and
// the result register is loaded, from which the result is offered.
// A new word is accepted every cycle as long as results are taken.
// Synchronous reset clears pointers, full flags and valid bits and loads config reset values.
// A stalled result holds both stages; input ready drops once the input register is full.
`default_nettype none
`include "assert_macros.svh"

module can_frame_queue_router_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [cfqr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [cfqr_pkg::ID_W-1:0]         cfg_wdata,
  cfqr_in_if.sink                                in_if,
  cfqr_out_if.source                             out_if
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int IW = cfqr_pkg::ID_W;
  localparam int LW = cfqr_pkg::LEN_W;
  localparam int DW = cfqr_pkg::DATA_W;
  localparam int WW = cfqr_pkg::WORD_W;

  logic [IW-1:0] app_rx_id_r;
  logic [IW-1:0] diag_id_base_r;

  logic                        s1_v_r;
  logic [cfqr_pkg::FUNC_W-1:0] s1_func_r;
  logic [IW-1:0]               s1_id_r;
  logic [LW-1:0]               s1_len_r;
  logic [DW-1:0]               s1_data_r;
  logic                        s2_v_r;
  cfqr_pkg::stage_flags_t      s2_flags_r;

  logic                   in_accept;
  logic                   adv2;
  logic                   fire;
  logic [LW-1:0]          len_sat;
  logic [WW-1:0]          wr_word;
  logic [WW-1:0]          rd_word;
  logic [WW-1:0]          pri_rdata;
  logic [WW-1:0]          mon_rdata;
  logic                   pri_we;
  logic [PW+1:0]          pri_waddr;
  logic                   mon_we;
  logic [PW-1:0]          mon_waddr;
  logic                   pri_re;
  logic [PW+1:0]          pri_raddr;
  logic                   mon_re;
  logic [PW-1:0]          mon_raddr;
  cfqr_pkg::stage_flags_t flags;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_rx_id_r    <= cfqr_pkg::APP_RX_ID_RST;
      diag_id_base_r <= cfqr_pkg::DIAG_ID_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfqr_pkg::cfg_reg_t'(cfg_idx))
        cfqr_pkg::REG_APP_RX_ID:    app_rx_id_r    <= cfg_wdata;
        cfqr_pkg::REG_DIAG_ID_BASE: diag_id_base_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the second stage moves when empty or taken, the first follows it.
  assign adv2        = !s2_v_r || out_if.ready;
  assign fire        = s1_v_r && adv2;
  assign in_if.ready = !s1_v_r || adv2;
  assign in_accept   = in_if.valid && in_if.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r <= in_if.func;
      s1_id_r   <= in_if.frame_id;
      s1_len_r  <= in_if.frame_len;
      s1_data_r <= in_if.frame_data;
    end
  end

  // Stored frame: identifier, saturated length, data bytes.
  assign len_sat = (s1_len_r > cfqr_pkg::MAX_LEN) ? cfqr_pkg::MAX_LEN : s1_len_r;
  assign wr_word = {s1_id_r, len_sat, s1_data_r};

  cfqr_queue_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .func         (cfqr_pkg::func_t'(s1_func_r)),
    .frame_id     (s1_id_r),
    .app_rx_id    (app_rx_id_r),
    .diag_id_base (diag_id_base_r),
    .pri_we       (pri_we),
    .pri_waddr    (pri_waddr),
    .mon_we       (mon_we),
    .mon_waddr    (mon_waddr),
    .pri_re       (pri_re),
    .pri_raddr    (pri_raddr),
    .mon_re       (mon_re),
    .mon_raddr    (mon_raddr),
    .flags        (flags)
  );

  // The four rx and tx queues share one memory.
  cfqr_frame_mem #(
    .AW (PW + 2),
    .DW (WW)
  ) u_pri_mem (
    .clk   (clk),
    .we    (pri_we),
    .waddr (pri_waddr),
    .wdata (wr_word),
    .re    (pri_re),
    .raddr (pri_raddr),
    .rdata (pri_rdata)
  );

  // The monitor queue has its own memory, so a frame can go to both at once.
  cfqr_frame_mem #(
    .AW (PW),
    .DW (WW)
  ) u_mon_mem (
    .clk   (clk),
    .we    (mon_we),
    .waddr (mon_waddr),
    .wdata (wr_word),
    .re    (mon_re),
    .raddr (mon_raddr),
    .rdata (mon_rdata)
  );

  // Result register; the popped frame itself sits in the memory read register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s2_flags_r <= flags;
    end
  end

  // Result word; frame fields read as zero when nothing was popped.
  assign rd_word               = s2_flags_r.from_mon ? mon_rdata : pri_rdata;
  assign out_if.valid          = s2_v_r;
  assign out_if.found          = s2_flags_r.found;
  assign out_if.out_id         = s2_flags_r.found ? rd_word[WW-1:LW+DW] : '0;
  assign out_if.out_len        = s2_flags_r.found ? rd_word[LW+DW-1:DW] : '0;
  assign out_if.out_data       = s2_flags_r.found ? rd_word[DW-1:0] : '0;
  assign out_if.tx_source      = s2_flags_r.tx_source;
  assign out_if.stored_primary = s2_flags_r.stored_primary;
  assign out_if.stored_monitor = s2_flags_r.stored_monitor;

  // A tx origin is only reported with a popped frame.
  `CFQR_ASSERT_ALWAYS(a_txsrc_found,
    !out_if.valid || out_if.tx_source == cfqr_pkg::TX_SRC_NONE || out_if.found,
    "tx_source set without a returned frame")

  // A word either pops or stores, never both.
  `CFQR_ASSERT_ALWAYS(a_pop_or_store,
    !out_if.valid || !(out_if.found && (out_if.stored_primary || out_if.stored_monitor)),
    "result word both popped and stored a frame")

  // A word leaving the input register lands in the result register.
  `CFQR_ASSERT_NEXT(a_fire_result, fire, s2_v_r,
    "processed word missing from result register")

endmodule

`default_nettype wire
